/* rtl/yrr_pkg.sv */
// Package: shared types and constants for the YUV422 to RGB resize unit.
`timescale 1ns / 1ps
package yrr_pkg;

    localparam int DefMaxWidth  = 256;
    localparam int DefMaxHeight = 256;
    localparam int StoreAw      = 17;
    localparam int SizeW        = 9;

    localparam logic [2:0] CfgSrcWidth  = 3'd0;
    localparam logic [2:0] CfgSrcHeight = 3'd1;
    localparam logic [2:0] CfgTgtWidth  = 3'd2;
    localparam logic [2:0] CfgTgtHeight = 3'd3;
    localparam logic [2:0] CfgColorMode = 3'd4;
    localparam logic [2:0] CfgRotate    = 3'd5;

    localparam logic OpStore   = 1'b0;
    localparam logic OpConvert = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [16:0] byte_address;
        logic [7:0]  byte_value;
        logic [7:0]  out_row;
        logic [7:0]  out_col;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  gray;
    } out_item_t;

    // Request from front to back through the queue
    typedef struct packed {
        logic               is_store;
        logic [StoreAw-1:0] addr0;
        logic [StoreAw-1:0] addr1;
        logic [StoreAw-1:0] addr2;
        logic [7:0]         wdata;
        logic [15:0]        pidx;
        logic               color;
    } job_t;

    // Clip a signed value to 0..255
    function automatic logic [7:0] clip8(input logic signed [19:0] v);
        if (v < 0)
            return 8'd0;
        else if (v > 20'sd255)
            return 8'd255;
        else
            return v[7:0];
    endfunction

endpackage

/* rtl/yrr_divider.sv */
// Sequential restoring divider for the source coordinate scaling.
`timescale 1ns / 1ps
module yrr_divider
    import yrr_pkg::*;
#(
    parameter int NumW = 18,
    parameter int DenW = 11
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NumW-1:0] num,
    input  logic [DenW-1:0] den,
    output logic            done,
    output logic [NumW-1:0] quot
);
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] q_reg, q_next;
    logic [DenW:0]   rem_reg, rem_next;
    logic [DenW-1:0] den_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DenW:0]   shifted;
    logic [DenW:0]   diff;

    // One quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg[DenW-1:0], q_reg[NumW-1]};
        diff      = shifted - {1'b0, den_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = num;
            rem_next  = '0;
            cnt_next  = CntW'(NumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DenW])
            begin
                rem_next = diff;
                q_next   = {q_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[NumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= den;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

/* rtl/yrr_front.sv */
// Front end: takes requests, drops off-image pixels, maps coordinates to addresses.
`timescale 1ns / 1ps
module yrr_front
    import yrr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    input  logic [SizeW-1:0] src_w,
    input  logic [SizeW-1:0] src_h,
    input  logic [SizeW-1:0] tgt_w,
    input  logic [SizeW-1:0] tgt_h,
    input  logic             color,
    input  logic             rotate,
    output logic             job_valid,
    input  logic             job_full,
    output job_t             job
);
    localparam int NumW = 8 + SizeW;

    typedef enum logic [2:0] {S_IDLE, S_DIVR, S_DIVC, S_ADDR, S_PUSH} state_t;

    state_t          state_reg;
    in_item_t        item_reg;
    logic [8:0]      srow_reg;
    logic [17:0]     luma_reg;
    logic            div_start;
    logic [NumW-1:0] div_num;
    logic [SizeW-1:0] div_den;
    logic            div_done;
    logic [NumW-1:0] div_q;
    logic            accept;
    logic            in_range;
    logic [17:0]     plane;
    logic [16:0]     chroma;
    logic [17:0]     pidx_w;
    logic            job_valid_reg;
    job_t            job_reg;

    assign in_stall = (state_reg != S_IDLE) || job_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign in_range = ({1'b0, in_data.out_row} < tgt_h) && ({1'b0, in_data.out_col} < tgt_w);

    assign div_start = (state_reg == S_IDLE && accept && in_data.opcode == OpConvert
                        && in_range) || (state_reg == S_DIVR && div_done);
    assign div_num = (state_reg == S_IDLE) ? NumW'(in_data.out_row) * NumW'(src_h)
                                           : NumW'(item_reg.out_col) * NumW'(src_w);
    assign div_den = (state_reg == S_IDLE) ? tgt_h : tgt_w;

    yrr_divider #(.NumW(NumW), .DenW(SizeW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // Plane and output index
    assign plane  = 18'(src_w) * 18'(src_h);
    assign chroma = 17'(luma_reg >> 1);
    assign pidx_w = rotate
        ? 18'(tgt_w - 9'd1 - {1'b0, item_reg.out_col}) * 18'(tgt_h) + 18'(item_reg.out_row)
        : 18'(item_reg.out_row) * 18'(tgt_w) + 18'(item_reg.out_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_valid_reg && !job_full)
                job_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (accept)
                    begin
                        if (in_data.opcode == OpStore)
                            job_valid_reg <= 1'b1;
                        else if (in_range)
                            state_reg <= S_DIVR;
                    end
                S_DIVR:
                    if (div_done)
                        state_reg <= S_DIVC;
                S_DIVC:
                    if (div_done)
                        state_reg <= S_ADDR;
                S_ADDR:
                    state_reg <= S_PUSH;
                S_PUSH:
                begin
                    job_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg         <= in_data;
            job_reg.is_store <= 1'b1;
            job_reg.addr0    <= in_data.byte_address;
            job_reg.wdata    <= in_data.byte_value;
        end
        if (state_reg == S_DIVR && div_done)
            srow_reg <= div_q[8:0];
        if (state_reg == S_DIVC && div_done)
            luma_reg <= 18'(srow_reg) * 18'(src_w) + 18'(div_q[8:0]);
        if (state_reg == S_ADDR)
        begin
            job_reg.is_store <= 1'b0;
            job_reg.addr0    <= luma_reg[16:0];
            job_reg.addr1    <= 17'(plane) + chroma;
            job_reg.addr2    <= 17'(plane) + 17'(plane >> 1) + chroma;
            job_reg.pidx     <= pidx_w[15:0];
            job_reg.color    <= color;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;
endmodule

/* rtl/yrr_queue.sv */
// Two-entry request queue between front and back ends.
`timescale 1ns / 1ps
module yrr_queue
    import yrr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);
    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= ~wp_reg;
            if (pop && !empty)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(pop && !empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= push_data;
    end
endmodule

/* rtl/yrr_back.sv */
// Back end: frame memory, three reads per pixel, color conversion, output register.
`timescale 1ns / 1ps
module yrr_back
    import yrr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  job_t      q_head,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);
    typedef enum logic [2:0] {B_IDLE, B_RDY, B_RDU, B_RDV, B_MUL, B_SUM, B_LUM, B_OUT} state_t;

    // Reciprocals, exact for magnitudes below 2^22 and 2^20
    localparam logic [22:0] RecipTenK     = 23'd6871948;   // ceil(2^36 / 10000)
    localparam logic [20:0] RecipThousand = 21'd1073742;   // ceil(2^30 / 1000)

    state_t           state_reg;
    logic [7:0]       mem [2**StoreAw];
    logic [7:0]       rd_reg;
    logic [StoreAw-1:0] raddr;
    logic [7:0]       y_reg, u_reg;
    job_t             job_reg;
    logic signed [8:0]  d_s, e_s;
    logic signed [23:0] p_rd_reg, p_gu_reg, p_gd_reg, p_bu_reg;
    logic signed [19:0] q_rd_reg, q_gu_reg, q_gd_reg, q_bu_reg;
    logic signed [19:0] r_reg, g_reg, b_reg;
    logic signed [31:0] lum_reg;
    logic [19:0]        lum_m;
    logic [40:0]        lum_p;
    logic signed [19:0] lum_c;
    logic               out_valid_reg;
    out_item_t          out_reg;
    logic               start;
    logic               out_take;

    assign start    = (state_reg == B_IDLE) && !q_empty;
    assign q_pop    = start;
    assign out_take = (state_reg == B_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        case (state_reg)
            B_RDY:   raddr = job_reg.addr1;
            B_RDU:   raddr = job_reg.addr2;
            default: raddr = q_head.addr0;
        endcase
    end

    // Frame memory, single port
    always_ff @(posedge clk)
    begin
        if (start && q_head.is_store)
            mem[q_head.addr0] <= q_head.wdata;
        rd_reg <= mem[raddr];
    end

    assign e_s = $signed({1'b0, u_reg}) - 9'sd128;
    assign d_s = $signed({1'b0, rd_reg}) - 9'sd128;

    // Luma divide by 1000 on the magnitude, sign restored for truncation toward zero
    assign lum_m = (lum_reg < 0) ? 20'(-lum_reg) : 20'(lum_reg);
    assign lum_p = 41'(lum_m) * 41'(RecipThousand);
    assign lum_c = (lum_reg < 0) ? -20'(lum_p[40:30]) : 20'(lum_p[40:30]);

    function automatic logic signed [19:0] div10k(input logic signed [23:0] v);
        logic [23:0] m;
        logic [46:0] prod;
        m    = (v < 0) ? 24'(-v) : 24'(v);
        prod = 47'(m) * 47'(RecipTenK);
        return (v < 0) ? -20'(prod[46:36]) : 20'(prod[46:36]);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_take)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                    if (start && !q_head.is_store)
                        state_reg <= B_RDY;
                B_RDY: state_reg <= B_RDU;
                B_RDU: state_reg <= B_RDV;
                B_RDV: state_reg <= B_MUL;
                B_MUL: state_reg <= B_SUM;
                B_SUM: state_reg <= B_LUM;
                B_LUM: state_reg <= B_OUT;
                B_OUT:
                    if (out_take)
                        state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            job_reg <= q_head;
        // rd_reg holds Y in B_RDY, Cb in B_RDU, Cr in B_RDV
        if (state_reg == B_RDY)
            y_reg <= rd_reg;
        if (state_reg == B_RDU)
            u_reg <= rd_reg;
        if (state_reg == B_RDV)
        begin
            p_rd_reg <= 24'(d_s) * 24'sd14065;
            p_gd_reg <= 24'(d_s) * 24'sd7169;
            p_gu_reg <= 24'(e_s) * 24'sd3455;
            p_bu_reg <= 24'(e_s) * 24'sd17790;
        end
        if (state_reg == B_MUL)
        begin
            q_rd_reg <= div10k(p_rd_reg);
            q_gd_reg <= div10k(p_gd_reg);
            q_gu_reg <= div10k(p_gu_reg);
            q_bu_reg <= div10k(p_bu_reg);
        end
        if (state_reg == B_SUM)
        begin
            r_reg <= 20'(y_reg) + q_rd_reg;
            g_reg <= 20'(y_reg) - q_gu_reg - q_gd_reg;
            b_reg <= 20'(y_reg) + q_bu_reg;
        end
        if (state_reg == B_LUM)
            lum_reg <= 32'(r_reg) * 32'sd299 + 32'(g_reg) * 32'sd587 + 32'(b_reg) * 32'sd114;
        if (out_take)
        begin
            out_reg.pixel_index <= job_reg.pidx;
            out_reg.red   <= job_reg.color ? clip8(r_reg) : 8'd0;
            out_reg.green <= job_reg.color ? clip8(g_reg) : 8'd0;
            out_reg.blue  <= job_reg.color ? clip8(b_reg) : 8'd0;
            out_reg.gray  <= job_reg.color ? 8'd0 : clip8(lum_c);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

/* rtl/yuv422_planar_to_rgb_resize_unit.sv */
// Top level: YUV422 planar frame store with nearest-neighbor resize to RGB or gray.
// A store request writes one frame byte; the front end takes no new request until the
// store has been handed to the queue. A convert request holds the input in the front end
// for two sequential divisions (source row and column), address setup and the handoff to
// the queue, and then passes in the back end through three reads of the single-port frame
// memory, multiply, scaling by 1/10000, sum, luma and output; the front end takes no new
// request until the previous one has been handed to the queue, and the two-entry queue
// lets both ends stall independently.
// Sizes above MaxWidth/MaxHeight clamp to them, zero acts as one. Pixels outside
// the target image produce no result.
`timescale 1ns / 1ps
module yuv422_planar_to_rgb_resize_unit
    import yrr_pkg::*;
#(
    parameter int MaxWidth  = DefMaxWidth,
    parameter int MaxHeight = DefMaxHeight
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    logic [SizeW-1:0] src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    logic             color_reg, rotate_reg;
    logic             job_valid, q_full, q_empty, q_pop;
    job_t             job, q_head;

    // Clamp a size to 1..limit
    function automatic logic [SizeW-1:0] clamp(input logic [8:0] v, input int lim);
        if (v == 9'd0)
            return SizeW'(1);
        else if (int'(v) > lim)
            return SizeW'(lim);
        else
            return v;
    endfunction

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg  <= SizeW'(160);
            src_h_reg  <= SizeW'(160);
            tgt_w_reg  <= SizeW'(160);
            tgt_h_reg  <= SizeW'(160);
            color_reg  <= 1'b1;
            rotate_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CfgSrcWidth:  src_w_reg  <= clamp(cfg_data, MaxWidth);
                CfgSrcHeight: src_h_reg  <= clamp(cfg_data, MaxHeight);
                CfgTgtWidth:  tgt_w_reg  <= clamp(cfg_data, MaxWidth);
                CfgTgtHeight: tgt_h_reg  <= clamp(cfg_data, MaxHeight);
                CfgColorMode: color_reg  <= cfg_data[0];
                CfgRotate:    rotate_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    yrr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .src_w     (src_w_reg),
        .src_h     (src_h_reg),
        .tgt_w     (tgt_w_reg),
        .tgt_h     (tgt_h_reg),
        .color     (color_reg),
        .rotate    (rotate_reg),
        .job_valid (job_valid),
        .job_full  (q_full),
        .job       (job)
    );

    yrr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_valid),
        .push_data (job),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    yrr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );
endmodule

/* rtl/yrr_checker.sv */
// Port checker for the resize unit, bound to the top level.
`timescale 1ns / 1ps
module yrr_checker
    import yrr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);
    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // A store request is never followed by another request on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.opcode == OpStore |=> in_stall)
        else $error("request taken back to back");

    // A valid result carries known data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("result data unknown");

    // The result channel is silent out of reset
    assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");
endmodule

bind yuv422_planar_to_rgb_resize_unit yrr_checker u_yrr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
